// File: sv/nss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nss_pkg
// Shared widths, item codes and helpers for the nearly sorted search block.
// ----------------------------------------------------------------------------
package nss_pkg;

	localparam int NSS_DEPTH_DEF = 64;   // default table depth
	localparam int NSS_VAL_W     = 32;   // entry and key width
	localparam int NSS_IDX_W     = 6;    // write index and result position width
	localparam int NSS_LEN_W     = 7;    // length register width
	localparam int NSS_CNT_W     = 13;   // holds any depth up to 4096
	localparam int NSS_SDATA_W   = 40;   // index + value, padded to bytes
	localparam int NSS_MDATA_W   = 8;    // position, padded to bytes

	typedef enum logic {
		OP_WRITE  = 1'b0,
		OP_SEARCH = 1'b1
	} nss_op_t;

	// address width of a table with the given depth, at least one bit
	function automatic int nss_addr_w(input int depth);
		return (depth > 1) ? $clog2(depth) : 1;
	endfunction

endpackage
`default_nettype wire

// File: sv/nss_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nss_table
// Table storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module nss_table
	import nss_pkg::*;
#(
	parameter int DEPTH = NSS_DEPTH_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               wr_en,
	input  wire logic [nss_addr_w(DEPTH)-1:0]       waddr,
	input  wire logic signed [NSS_VAL_W-1:0]        wdata,
	input  wire logic [nss_addr_w(DEPTH)-1:0]       raddr,
	output      logic signed [NSS_VAL_W-1:0]        rdata
);

	logic signed [NSS_VAL_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// File: sv/nss_search.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nss_search
// Item sequencer: stores write words, walks the search window one table read
// per cycle, and holds the result in an output register.
// ----------------------------------------------------------------------------
module nss_search
	import nss_pkg::*;
#(
	parameter int DEPTH = NSS_DEPTH_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic [NSS_CNT_W-1:0]               len_eff,
	input  wire logic                               s_tvalid,
	output      logic                               s_tready,
	input  wire logic [NSS_SDATA_W-1:0]             s_tdata,
	input  wire logic [0:0]                         s_tuser,
	output      logic                               m_tvalid,
	input  wire logic                               m_tready,
	output      logic [NSS_MDATA_W-1:0]             m_tdata,
	output      logic [0:0]                         m_tuser,
	output      logic                               wr_en,
	output      logic [nss_addr_w(DEPTH)-1:0]       waddr,
	output      logic signed [NSS_VAL_W-1:0]        wdata,
	output      logic [nss_addr_w(DEPTH)-1:0]       raddr,
	input  wire logic signed [NSS_VAL_W-1:0]        rdata
);

	localparam int AW = nss_addr_w(DEPTH);
	localparam int IW = AW + 2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_MID,
		ST_LEFT,
		ST_RIGHT,
		ST_DONE
	} state_t;

	state_t                     state_q;
	logic signed [IW-1:0]       lo_q, hi_q;
	logic [AW-1:0]              mid_q;
	logic signed [NSS_VAL_W-1:0] key_q, here_q;
	logic                       found_q;
	logic [NSS_IDX_W-1:0]       pos_q;
	logic                       m_valid_q;
	logic                       m_found_q;
	logic [NSS_IDX_W-1:0]       m_pos_q;

	logic [NSS_IDX_W-1:0]       in_index;
	logic signed [NSS_VAL_W-1:0] in_value;
	nss_op_t                    in_op;
	logic                       accept;
	logic [IW-1:0]              sum;
	logic [AW-1:0]              mid_c;
	logic signed [IW-1:0]       mid_ext;
	logic                       left_ok, right_ok, rd_hit, narrow_gt;
	logic signed [IW-1:0]       lo_nar, hi_nar;

	assign in_index = s_tdata[NSS_IDX_W-1:0];
	assign in_value = s_tdata[NSS_IDX_W+NSS_VAL_W-1:NSS_IDX_W];
	assign in_op    = nss_op_t'(s_tuser[0]);

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	// write words go straight into the table; drop indexes past the depth
	assign wr_en = accept && (in_op == OP_WRITE)
		&& (NSS_CNT_W'(in_index) < NSS_CNT_W'(DEPTH));
	assign waddr = AW'(in_index);
	assign wdata = in_value;

	assign sum      = lo_q + hi_q;
	assign mid_c    = sum[AW:1];
	assign mid_ext  = $signed(IW'(mid_q));
	assign left_ok  = mid_ext > lo_q;
	assign right_ok = mid_ext < hi_q;
	assign rd_hit   = (rdata == key_q);
	assign narrow_gt = (state_q == ST_MID) ? (rdata > key_q) : (here_q > key_q);

	// narrow the window by two past the middle, toward the key
	always_comb begin
		lo_nar = lo_q;
		hi_nar = hi_q;
		if (narrow_gt) begin
			hi_nar = mid_ext - IW'(2);
		end else begin
			lo_nar = mid_ext + IW'(2);
		end
	end

	always_comb begin
		case (state_q)
			ST_CHECK: raddr = mid_c;
			ST_MID:   raddr = left_ok ? (mid_q - AW'(1)) : (mid_q + AW'(1));
			default:  raddr = mid_q + AW'(1);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			// load the output register from the done step, else drain it
			if ((state_q == ST_DONE) && (!m_valid_q || m_tready)) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && (in_op == OP_SEARCH)) begin
						key_q   <= in_value;
						lo_q    <= '0;
						hi_q    <= $signed(IW'(len_eff) - IW'(1));
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (lo_q > hi_q) begin
						found_q <= 1'b0;
						pos_q   <= '0;
						state_q <= ST_DONE;
					end else begin
						mid_q   <= mid_c;
						state_q <= ST_MID;
					end
				end
				ST_MID: begin
					here_q <= rdata;
					if (rd_hit) begin
						found_q <= 1'b1;
						pos_q   <= NSS_IDX_W'(mid_q);
						state_q <= ST_DONE;
					end else if (left_ok) begin
						state_q <= ST_LEFT;
					end else if (right_ok) begin
						state_q <= ST_RIGHT;
					end else begin
						lo_q    <= lo_nar;
						hi_q    <= hi_nar;
						state_q <= ST_CHECK;
					end
				end
				ST_LEFT: begin
					if (rd_hit) begin
						found_q <= 1'b1;
						pos_q   <= NSS_IDX_W'(mid_q - AW'(1));
						state_q <= ST_DONE;
					end else if (right_ok) begin
						state_q <= ST_RIGHT;
					end else begin
						lo_q    <= lo_nar;
						hi_q    <= hi_nar;
						state_q <= ST_CHECK;
					end
				end
				ST_RIGHT: begin
					if (rd_hit) begin
						found_q <= 1'b1;
						pos_q   <= NSS_IDX_W'(mid_q + AW'(1));
						state_q <= ST_DONE;
					end else begin
						lo_q    <= lo_nar;
						hi_q    <= hi_nar;
						state_q <= ST_CHECK;
					end
				end
				ST_DONE: begin
					// hold until the output register is free
					if (!m_valid_q || m_tready) begin
						m_found_q <= found_q;
						m_pos_q   <= pos_q;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = NSS_MDATA_W'(m_pos_q);
	assign m_tuser  = m_found_q;

endmodule
`default_nettype wire

// File: sv/nearly_sorted_search.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nearly_sorted_search
// Search over a nearly sorted table of signed 32-bit entries.
// ----------------------------------------------------------------------------
// Input stream (s_*): one word per item. s_tuser selects the item kind:
// 0 stores value at table slot index and gives no result, 1 searches the
// first length entries for value. Output stream (m_*): one word per search,
// found in m_tuser and the matching position in m_tdata (0 when not found).
// Config channel (cfg_*): writes the length register; write it only while
// the block is idle. Lengths above DEPTH are clamped to DEPTH.
// Operation: a write word is stored in the table when it is taken. A
// search runs probes, each a window check, then one table read each for
// the middle entry and its in-window neighbors; each probe more than
// halves the window, so 64 entries need at most five probes. The single
// table read port sets the pace of the probes, and the next word is taken
// once the result is in the output register. The block takes one item at
// a time. The result sits in an output register, so a new item
// is accepted while the previous result waits; a stalled receiver only
// holds the next search at its final step. Reset clears the length to 0 and
// empties the output; table contents are undefined until written.
// ----------------------------------------------------------------------------
module nearly_sorted_search
	import nss_pkg::*;
#(
	parameter int DEPTH = NSS_DEPTH_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	// config write channel
	input  wire logic                       cfg_valid,
	output      logic                       cfg_ready,
	input  wire logic [NSS_LEN_W-1:0]       cfg_data,      // length
	// input stream
	input  wire logic                       s_tvalid,
	output      logic                       s_tready,
	input  wire logic [NSS_SDATA_W-1:0]     s_tdata,       // [5:0] index, [37:6] value
	input  wire logic [0:0]                 s_tuser,       // [0] op
	// output stream
	output      logic                       m_tvalid,
	input  wire logic                       m_tready,
	output      logic [NSS_MDATA_W-1:0]     m_tdata,       // [5:0] position
	output      logic [0:0]                 m_tuser        // [0] found
);

	localparam int AW = nss_addr_w(DEPTH);

	logic [NSS_LEN_W-1:0]        length_q;
	logic [NSS_CNT_W-1:0]        len_eff;
	logic                        wr_en;
	logic [AW-1:0]               waddr, raddr;
	logic signed [NSS_VAL_W-1:0] wdata, rdata;

	// config is always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			length_q <= cfg_data;
		end
	end

	// clamp the search length to the table depth
	assign len_eff = (NSS_CNT_W'(length_q) > NSS_CNT_W'(DEPTH))
		? NSS_CNT_W'(DEPTH) : NSS_CNT_W'(length_q);

	nss_search #(
		.DEPTH (DEPTH)
	) u_search (
		.clk      (clk),
		.arst_n   (arst_n),
		.len_eff  (len_eff),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.wr_en    (wr_en),
		.waddr    (waddr),
		.wdata    (wdata),
		.raddr    (raddr),
		.rdata    (rdata)
	);

	nss_table #(
		.DEPTH (DEPTH)
	) u_table (
		.clk   (clk),
		.wr_en (wr_en),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

endmodule
`default_nettype wire
